// ===== rtl/core/ipv6tap_pkg.sv =====
// Shared types, constants and the character decoder of the IPv6 text address parser.
// Used by ipv6tap_core, ipv6tap_pack and ipv6_text_address_parser; depends on nothing.
package ipv6tap_pkg;

  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned GROUP_W      = 16;
  localparam int unsigned NIBBLE_W     = 4;
  localparam int unsigned SHOWN_GROUPS = 8;
  localparam int unsigned HALF_W       = 64;

  localparam logic [CHAR_W-1:0] COLON_CHAR = 8'h3A;
  localparam logic [CHAR_W-1:0] DIGIT_LO   = 8'h30;
  localparam logic [CHAR_W-1:0] DIGIT_HI   = 8'h39;
  localparam logic [CHAR_W-1:0] LOWER_LO   = 8'h61;
  localparam logic [CHAR_W-1:0] LOWER_HI   = 8'h66;
  localparam logic [CHAR_W-1:0] UPPER_LO   = 8'h41;
  localparam logic [CHAR_W-1:0] UPPER_HI   = 8'h46;
  localparam logic [CHAR_W-1:0] LETTER_OFS = 8'd10;

  typedef struct packed {
    logic                valid;
    logic [NIBBLE_W-1:0] value;
  } hex_t;

  typedef struct packed {
    logic valid;
    logic ok;
  } fin_ctrl_t;

  function automatic hex_t hex_decode(logic [CHAR_W-1:0] c);
    hex_t              r;
    logic [CHAR_W-1:0] v;
    r = '0;
    v = '0;
    if (c >= DIGIT_LO && c <= DIGIT_HI) begin
      r.valid = 1'b1;
      v = c - DIGIT_LO;
    end else if (c >= LOWER_LO && c <= LOWER_HI) begin
      r.valid = 1'b1;
      v = c - LOWER_LO + LETTER_OFS;
    end else if (c >= UPPER_LO && c <= UPPER_HI) begin
      r.valid = 1'b1;
      v = c - UPPER_LO + LETTER_OFS;
    end
    r.value = v[NIBBLE_W-1:0];
    return r;
  endfunction

endpackage

// ===== rtl/core/ipv6_text_address_parser.sv =====
// IPv6 text address parser, top level: one character of address text per transfer, with tlast on
// the final character; one result transfer per address carries the 128-bit address and a fail
// flag in tuser. A character is taken every cycle unless the input stalls; the result appears in
// the cycle after the final character is taken. The input stalls only while a result waits and the
// output is not ready, since a single result register sits between the character logic and the
// output. Failed addresses read as all zeros. Depends on ipv6tap_pkg, ipv6tap_core and ipv6tap_pack.
module ipv6_text_address_parser #(
  parameter int unsigned GROUPS = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] char_code
  input  logic         s_axis_tlast,   // is_last
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // [63:0] addr_high, [127:64] addr_low
  output logic         m_axis_tuser    // parse_fail
);

  localparam int unsigned CW = $clog2(GROUPS + 1);
  localparam int unsigned GW = ipv6tap_pkg::GROUP_W;

  logic                          accept;
  ipv6tap_pkg::fin_ctrl_t        fin;
  logic [CW-1:0]                 fin_count;
  logic [CW-1:0]                 fin_split;
  logic [GW-1:0]                 fin_head [GROUPS];
  logic [GW-1:0]                 fin_tail [GROUPS];
  logic [ipv6tap_pkg::HALF_W-1:0] addr_high, addr_low;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  ipv6tap_core #(
    .GROUPS (GROUPS),
    .CW     (CW)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .char_i      (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .fin_o       (fin),
    .fin_count_o (fin_count),
    .fin_split_o (fin_split),
    .fin_head_o  (fin_head),
    .fin_tail_o  (fin_tail)
  );

  ipv6tap_pack #(
    .GROUPS (GROUPS),
    .CW     (CW)
  ) u_pack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fin_i        (fin),
    .fin_count_i  (fin_count),
    .fin_split_i  (fin_split),
    .fin_head_i   (fin_head),
    .fin_tail_i   (fin_tail),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .addr_high_o  (addr_high),
    .addr_low_o   (addr_low),
    .parse_fail_o (m_axis_tuser)
  );

  assign m_axis_tdata = {addr_low, addr_high};

endmodule

// ===== rtl/core/ipv6tap_core.sv =====
// Character-level parser state of the IPv6 text address parser: group build, colon and split
// handling, and the closing view of the stored groups on the final character. Uses ipv6tap_pkg.
module ipv6tap_core #(
  parameter int unsigned GROUPS = 8,
  parameter int unsigned CW     = $clog2(GROUPS + 1)
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   accept_i,
  input  logic [ipv6tap_pkg::CHAR_W-1:0]         char_i,
  input  logic                                   last_i,
  output ipv6tap_pkg::fin_ctrl_t                 fin_o,
  output logic [CW-1:0]                          fin_count_o,
  output logic [CW-1:0]                          fin_split_o,
  output logic [ipv6tap_pkg::GROUP_W-1:0]        fin_head_o [GROUPS],
  output logic [ipv6tap_pkg::GROUP_W-1:0]        fin_tail_o [GROUPS]
);

  localparam int unsigned GW = ipv6tap_pkg::GROUP_W;
  localparam int unsigned NW = ipv6tap_pkg::NIBBLE_W;
  localparam logic [CW-1:0] NO_SPLIT = CW'(GROUPS);

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] split_q, split_d;
  logic [GW-1:0] acc_q, acc_d;
  logic          prev_q, prev_d;
  logic          err_q, err_d;
  logic [GW-1:0] head_q [GROUPS];
  logic [GW-1:0] head_d [GROUPS];
  logic [GW-1:0] tail_q [GROUPS];
  logic [GW-1:0] tail_d [GROUPS];
  ipv6tap_pkg::hex_t hx;

  always_comb begin
    hx      = ipv6tap_pkg::hex_decode(char_i);
    count_d = count_q;
    split_d = split_q;
    acc_d   = acc_q;
    prev_d  = prev_q;
    err_d   = err_q;
    head_d  = head_q;
    tail_d  = tail_q;

    if (accept_i && !err_q) begin
      if (hx.valid) begin
        if (acc_q[GW-1 -: NW] != '0) begin
          err_d = 1'b1;
        end else begin
          acc_d  = {acc_q[GW-NW-1:0], hx.value};
          prev_d = 1'b0;
        end
      end else if (char_i == ipv6tap_pkg::COLON_CHAR) begin
        if (count_q >= NO_SPLIT) begin
          err_d = 1'b1;
        end else if (prev_q) begin
          if (split_q != NO_SPLIT) begin
            err_d = 1'b1;
          end else begin
            split_d = count_q;
          end
        end else begin
          if (split_q == NO_SPLIT) begin
            for (int i = 0; i < GROUPS; i++) begin
              if (count_q == CW'(i)) begin
                head_d[i] = acc_q;
              end
            end
          end else begin
            for (int i = 0; i < GROUPS - 1; i++) begin
              tail_d[i] = tail_q[i+1];
            end
            tail_d[GROUPS-1] = acc_q;
          end
          count_d = count_q + CW'(1);
          acc_d   = '0;
          prev_d  = 1'b1;
        end
      end else begin
        err_d = 1'b1;
      end
    end

    fin_head_o = head_d;
    fin_tail_o = tail_d;
    if (split_d == NO_SPLIT) begin
      for (int i = 0; i < GROUPS; i++) begin
        if (count_d == CW'(i)) begin
          fin_head_o[i] = acc_d;
        end
      end
    end else begin
      for (int i = 0; i < GROUPS - 1; i++) begin
        fin_tail_o[i] = tail_d[i+1];
      end
      fin_tail_o[GROUPS-1] = acc_d;
    end
    fin_count_o = count_d;
    fin_split_o = split_d;
    fin_o.valid = accept_i && last_i;
    fin_o.ok    = !err_d && count_d < NO_SPLIT &&
                  !(split_d == NO_SPLIT && count_d != CW'(GROUPS - 1));

    if (accept_i && last_i) begin
      count_d = '0;
      split_d = NO_SPLIT;
      acc_d   = '0;
      prev_d  = 1'b0;
      err_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      split_q <= NO_SPLIT;
      acc_q   <= '0;
      prev_q  <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      split_q <= split_d;
      acc_q   <= acc_d;
      prev_q  <= prev_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_i |=> count_q == '0 && split_q == NO_SPLIT && !err_q)
    else $error("parser state not cleared after the final character");

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= NO_SPLIT)
    else $error("group count beyond the number of groups");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    split_q == NO_SPLIT || split_q <= count_q)
    else $error("split position beyond the stored groups");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q && accept_i && !last_i |=> err_q)
    else $error("failure not held until the final character");

endmodule

// ===== rtl/core/ipv6tap_pack.sv =====
// Group compaction around the split, address packing and the result register with its transfer
// handshake for the IPv6 text address parser. Uses ipv6tap_pkg.
module ipv6tap_pack #(
  parameter int unsigned GROUPS = 8,
  parameter int unsigned CW     = $clog2(GROUPS + 1)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ipv6tap_pkg::fin_ctrl_t               fin_i,
  input  logic [CW-1:0]                        fin_count_i,
  input  logic [CW-1:0]                        fin_split_i,
  input  logic [ipv6tap_pkg::GROUP_W-1:0]      fin_head_i [GROUPS],
  input  logic [ipv6tap_pkg::GROUP_W-1:0]      fin_tail_i [GROUPS],
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic [ipv6tap_pkg::HALF_W-1:0]       addr_high_o,
  output logic [ipv6tap_pkg::HALF_W-1:0]       addr_low_o,
  output logic                                 parse_fail_o
);

  localparam int unsigned GW    = ipv6tap_pkg::GROUP_W;
  localparam int unsigned SHOWN = ipv6tap_pkg::SHOWN_GROUPS;
  localparam int unsigned HALF  = SHOWN / 2;
  localparam int unsigned PADN  = (GROUPS > SHOWN) ? GROUPS : SHOWN;
  localparam logic [CW-1:0] NO_SPLIT = CW'(GROUPS);

  logic [CW:0]   n_ext;
  logic [CW:0]   tail_start;
  logic [GW-1:0] slot [PADN];
  logic [ipv6tap_pkg::HALF_W-1:0] high_d, low_d;

  logic                           valid_q, valid_d;
  logic [ipv6tap_pkg::HALF_W-1:0] high_q, low_q;
  logic                           fail_q;

  always_comb begin
    n_ext      = {1'b0, fin_count_i} + (CW+1)'(1);
    tail_start = (CW+1)'(GROUPS) - n_ext + {1'b0, fin_split_i};
    for (int i = 0; i < PADN; i++) begin
      slot[i] = '0;
    end
    for (int i = 0; i < GROUPS; i++) begin
      if (!fin_i.ok) begin
        slot[i] = '0;
      end else if (fin_split_i == NO_SPLIT || CW'(i) < fin_split_i) begin
        slot[i] = fin_head_i[i];
      end else if ((CW+1)'(i) >= tail_start) begin
        slot[i] = fin_tail_i[i];
      end else begin
        slot[i] = '0;
      end
    end
    for (int i = 0; i < HALF; i++) begin
      high_d[GW*(HALF-1-i) +: GW] = slot[i];
      low_d[GW*(HALF-1-i) +: GW]  = slot[i+HALF];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (fin_i.valid) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_i.valid) begin
      high_q <= high_d;
      low_q  <= low_d;
      fail_q <= !fin_i.ok;
    end
  end

  assign out_valid_o  = valid_q;
  assign addr_high_o  = high_q;
  assign addr_low_o   = low_q;
  assign parse_fail_o = fail_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) fin_i.valid |=> valid_q)
    else $error("closing character did not load a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && fail_q |-> high_q == '0 && low_q == '0)
    else $error("failed result carries a non-zero address");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_i.valid && fin_i.ok && fin_split_i != NO_SPLIT |-> fin_split_i <= fin_count_i)
    else $error("split lies beyond the closing group");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for ipv6_text_address_parser: streams address text one character
// per transfer and checks each address result against a built-in parser model.
// Depends on ipv6tap_pkg and the RTL of ipv6_text_address_parser.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N_GROUPS     = 8;
  localparam int unsigned N_SLOTS      = 16;
  localparam int unsigned RANDOM_CHARS = 800;
  localparam int unsigned MIN_ADDRS    = 60;
  localparam int unsigned RX_HOLD      = 60;
  localparam int unsigned QUIET_LIMIT  = 1000;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    logic [ipv6tap_pkg::CHAR_W-1:0] code;
    logic                           last;
    logic                           drain;
    logic                           hold;
    logic                           calm;
  } text_char_t;

  typedef struct packed {
    logic [ipv6tap_pkg::HALF_W-1:0] addr_high;
    logic [ipv6tap_pkg::HALF_W-1:0] addr_low;
    logic                           parse_fail;
  } addr_result_t;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata  = '0;   // [7:0] char_code
  logic         s_axis_tlast  = 1'b0; // is_last
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;         // [63:0] addr_high, [127:64] addr_low
  logic         m_axis_tuser;         // parse_fail

  text_char_t   char_q[$];
  addr_result_t addr_expect_q[$];
  logic [7:0]   addr_text[$];

  logic mark_drain = 1'b0;
  logic mark_hold  = 1'b0;
  logic mark_calm  = 1'b0;
  logic char_taken = 1'b0;
  logic hold_kick  = 1'b0;
  logic tx_calm    = 1'b0;

  int unsigned tx_gap_left   = 0;
  int unsigned rx_gap_left   = 0;
  int unsigned rx_stall_left = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned mismatches    = 0;
  int unsigned addrs_seen    = 0;

  logic [ipv6tap_pkg::GROUP_W-1:0] addr_groups [N_SLOTS];
  logic [3:0]                      groups_done;
  logic [3:0]                      split_at;
  logic [ipv6tap_pkg::GROUP_W-1:0] group_acc;
  logic                            after_colon;
  logic                            text_bad;

  ipv6_text_address_parser #(
    .GROUPS(N_GROUPS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void clear_parser();
    for (int i = 0; i < N_SLOTS; i++) begin
      addr_groups[i] = '0;
    end
    groups_done = '0;
    split_at    = 4'(N_GROUPS);
    group_acc   = '0;
    after_colon = 1'b0;
    text_bad    = 1'b0;
  endfunction

  function automatic void feed_char(logic [ipv6tap_pkg::CHAR_W-1:0] c);
    logic                             is_hex;
    logic [ipv6tap_pkg::NIBBLE_W-1:0] nib;
    is_hex = 1'b1;
    nib    = c[3:0];
    if ((c >= ipv6tap_pkg::LOWER_LO && c <= ipv6tap_pkg::LOWER_HI) ||
        (c >= ipv6tap_pkg::UPPER_LO && c <= ipv6tap_pkg::UPPER_HI)) begin
      nib = c[3:0] + 4'd9;
    end else if (!(c >= ipv6tap_pkg::DIGIT_LO && c <= ipv6tap_pkg::DIGIT_HI)) begin
      is_hex = 1'b0;
    end
    if (text_bad) begin
      return;
    end
    if (is_hex) begin
      if (group_acc[15:12] != '0) begin
        text_bad = 1'b1;
      end else begin
        group_acc   = {group_acc[11:0], nib};
        after_colon = 1'b0;
      end
    end else if (c == ipv6tap_pkg::COLON_CHAR) begin
      if (groups_done >= N_GROUPS) begin
        text_bad = 1'b1;
      end else if (after_colon) begin
        if (split_at != N_GROUPS) begin
          text_bad = 1'b1;
        end else begin
          split_at = groups_done;
        end
      end else begin
        addr_groups[groups_done] = group_acc;
        groups_done++;
        group_acc   = '0;
        after_colon = 1'b1;
      end
    end else begin
      text_bad = 1'b1;
    end
  endfunction

  function automatic addr_result_t close_address();
    addr_result_t r;
    int           used;
    int           tail;
    r            = '0;
    r.parse_fail = 1'b1;
    if (!text_bad && !(split_at == N_GROUPS && groups_done != N_GROUPS - 1) &&
        groups_done < N_GROUPS) begin
      addr_groups[groups_done] = group_acc;
      used = int'(groups_done) + 1;
      if (split_at != N_GROUPS) begin
        tail = used - int'(split_at);
        for (int i = 0; i < tail; i++) begin
          addr_groups[N_GROUPS - 1 - i] = addr_groups[used - 1 - i];
        end
        for (int i = int'(split_at); i < N_GROUPS - tail; i++) begin
          addr_groups[i] = '0;
        end
      end
      for (int i = 0; i < 4; i++) begin
        r.addr_high[63 - 16*i -: 16] = addr_groups[i];
        r.addr_low[63 - 16*i -: 16]  = addr_groups[i + 4];
      end
      r.parse_fail = 1'b0;
    end
    clear_parser();
    return r;
  endfunction

  function automatic void put_char(logic [ipv6tap_pkg::CHAR_W-1:0] c, logic last);
    char_q.push_back('{code: c, last: last, drain: mark_drain, hold: mark_hold,
                       calm: mark_calm});
    mark_drain = 1'b0;
    mark_hold  = 1'b0;
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      put_char(s[i], i == s.len() - 1);
    end
  endfunction

  function automatic void put_addr_text();
    for (int i = 0; i < addr_text.size(); i++) begin
      put_char(addr_text[i], i == addr_text.size() - 1);
    end
  endfunction

  function automatic logic [ipv6tap_pkg::CHAR_W-1:0] rand_hex();
    logic [ipv6tap_pkg::CHAR_W-1:0] v;
    v = 8'($urandom_range(0, 15));
    if (v < 10) begin
      return ipv6tap_pkg::DIGIT_LO + v;
    end else if ($urandom_range(0, 1) == 0) begin
      return ipv6tap_pkg::LOWER_LO + v - ipv6tap_pkg::LETTER_OFS;
    end
    return ipv6tap_pkg::UPPER_LO + v - ipv6tap_pkg::LETTER_OFS;
  endfunction

  function automatic void add_group();
    int digits;
    digits = $urandom_range(0, 7) == 0 ? 4 : $urandom_range(1, 3);
    for (int i = 0; i < digits; i++) begin
      addr_text.push_back(rand_hex());
    end
  endfunction

  function automatic void build_wellformed();
    int total;
    int left;
    if ($urandom_range(0, 2) == 0) begin
      for (int g = 0; g < N_GROUPS; g++) begin
        if (g > 0) begin
          addr_text.push_back(ipv6tap_pkg::COLON_CHAR);
        end
        add_group();
      end
    end else begin
      total = $urandom_range(0, 15) == 0 ? N_GROUPS : $urandom_range(0, N_GROUPS - 1);
      left  = $urandom_range(0, total);
      for (int g = 0; g < left; g++) begin
        if (g > 0) begin
          addr_text.push_back(ipv6tap_pkg::COLON_CHAR);
        end
        add_group();
      end
      addr_text.push_back(ipv6tap_pkg::COLON_CHAR);
      addr_text.push_back(ipv6tap_pkg::COLON_CHAR);
      for (int g = left; g < total; g++) begin
        if (g > left) begin
          addr_text.push_back(ipv6tap_pkg::COLON_CHAR);
        end
        add_group();
      end
    end
  endfunction

  function automatic void break_text();
    int pos;
    pos = $urandom_range(0, addr_text.size() - 1);
    case ($urandom_range(0, 4))
      0: begin
        addr_text[pos] = 8'($urandom_range(0, 255));
      end
      1: begin
        addr_text.insert(pos, ipv6tap_pkg::COLON_CHAR);
      end
      2: begin
        addr_text.insert(pos, rand_hex());
      end
      3: begin
        if (addr_text.size() > 1) begin
          addr_text.delete(pos);
        end
      end
      default: begin
        addr_text.push_back(ipv6tap_pkg::COLON_CHAR);
        addr_text.push_back(rand_hex());
      end
    endcase
  endfunction

  function automatic void build_noise();
    int len;
    int pick;
    len = $urandom_range(1, 10);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        addr_text.push_back(rand_hex());
      end else if (pick < 7) begin
        addr_text.push_back(ipv6tap_pkg::COLON_CHAR);
      end else begin
        addr_text.push_back(8'($urandom_range(0, 255)));
      end
    end
  endfunction

  always @(negedge clk_i) begin : drive_chars
    text_char_t                     item;
    logic                           valid_n;
    logic [ipv6tap_pkg::CHAR_W-1:0] data_n;
    logic                           last_n;
    logic                           kick_n;
    logic                           calm_n;
    valid_n = s_axis_tvalid;
    data_n  = s_axis_tdata;
    last_n  = s_axis_tlast;
    kick_n  = 1'b0;
    calm_n  = tx_calm;
    if (rst_ni && (!s_axis_tvalid || char_taken)) begin
      valid_n = 1'b0;
      if (tx_gap_left != 0) begin
        tx_gap_left--;
      end else if (char_q.size() != 0 && !(char_q[0].drain && addr_expect_q.size() != 0)) begin
        if (!char_q[0].calm && $urandom_range(0, 7) == 0) begin
          tx_gap_left = $urandom_range(0, 3);
        end else begin
          item    = char_q.pop_front();
          valid_n = 1'b1;
          data_n  = item.code;
          last_n  = item.last;
          kick_n  = item.hold;
          calm_n  = item.calm;
        end
      end
    end
    s_axis_tvalid <= valid_n;
    s_axis_tdata  <= data_n;
    s_axis_tlast  <= last_n;
    hold_kick     <= kick_n;
    tx_calm       <= calm_n;
  end

  always @(negedge clk_i) begin : drive_ready
    logic rdy;
    rdy = 1'b0;
    if (rst_ni) begin
      if (hold_kick) begin
        rx_stall_left = RX_HOLD;
      end
      if (rx_stall_left != 0) begin
        rx_stall_left--;
      end else if (rx_gap_left != 0) begin
        rx_gap_left--;
      end else if (!tx_calm && $urandom_range(0, 5) == 0) begin
        rx_gap_left = $urandom_range(0, 3);
      end else begin
        rdy = 1'b1;
      end
    end
    m_axis_tready <= rdy;
  end

  always @(posedge clk_i) begin : watch_ports
    addr_result_t got;
    addr_result_t want;
    if (!rst_ni) begin
      char_taken <= 1'b0;
    end else begin
      char_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        feed_char(s_axis_tdata);
        if (s_axis_tlast) begin
          addr_expect_q.push_back(close_address());
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{addr_high: m_axis_tdata[63:0], addr_low: m_axis_tdata[127:64],
                parse_fail: m_axis_tuser};
        addrs_seen++;
        if (addr_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("address %0d: unexpected result high %h low %h fail %b",
                     addrs_seen, got.addr_high, got.addr_low, got.parse_fail);
          end
        end else begin
          want = addr_expect_q.pop_front();
          if (got.addr_high !== want.addr_high || got.addr_low !== want.addr_low ||
              got.parse_fail !== want.parse_fail) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("address %0d: expected high %h low %h fail %b, got high %h low %h fail %b",
                       addrs_seen, want.addr_high, want.addr_low, want.parse_fail,
                       got.addr_high, got.addr_low, got.parse_fail);
            end
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout after %0d cycles without a transfer", quiet_cycles);
        $display("** ipv6_text_address_parser: FAILED **");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int n_chars;
    int n_addrs;
    int kind;
    clear_parser();

    put_text("::");
    put_text("1::");
    put_text("1:2::");
    put_text(":::");
    put_text("1::2::");
    put_text("12345");
    put_char(8'h00, 1'b1);
    put_char(8'hFF, 1'b1);
    put_text("g");
    put_text("1:2");
    put_text("x:");
    put_text("FFFF:0:0:0:0:0:0:ffff");
    put_text("aBcD:Ef09:1:2:3:4:5:6::");
    put_text("::1:2:3:4:5:6:7:8");

    n_chars    = 0;
    n_addrs    = 0;
    mark_drain = 1'b1;
    while (n_chars < RANDOM_CHARS || n_addrs < MIN_ADDRS) begin
      if (n_chars >= RANDOM_CHARS * 17 / 20) begin
        mark_calm = 1'b1;
      end
      if (n_addrs == 8 || n_addrs == 35) begin
        mark_hold = 1'b1;
      end
      if (n_addrs == 20) begin
        mark_drain = 1'b1;
      end
      addr_text.delete();
      kind = $urandom_range(0, 19);
      if (kind < 13) begin
        build_wellformed();
      end else if (kind < 17) begin
        build_wellformed();
        break_text();
      end else begin
        build_noise();
      end
      n_chars += addr_text.size();
      n_addrs++;
      put_addr_text();
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (char_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (addr_expect_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (mismatches == 0 && addr_expect_q.size() == 0) begin
      $display("** ipv6_text_address_parser: PASSED **");
    end else begin
      $display("** ipv6_text_address_parser: FAILED **");
    end
    $finish;
  end

endmodule
